// File: rtl/ccsc_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher package
// Shared types and constants for the ChaCha20 byte stream cipher unit.
// ----------------------------------------------------------------------------
package ccsc_pkg;

  localparam int unsigned DOUBLE_ROUNDS_DEFAULT = 10;
  localparam int unsigned QUEUE_DEPTH_DEFAULT   = 2;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned POS_W       = 6;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;

  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_A      = 3'd0,
    REG_KEY_B      = 3'd1,
    REG_KEY_C      = 3'd2,
    REG_KEY_D      = 3'd3,
    REG_NONCE_LOW  = 3'd4,
    REG_NONCE_HIGH = 3'd5,
    REG_START_CTR  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } data_req_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } result_req_t;

  typedef struct packed {
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [63:0] key_c;
    logic [63:0] key_d;
    logic [63:0] nonce_low;
    logic [31:0] nonce_high;
  } cipher_cfg_t;

  // One classified request on its way from the front end to the cipher core.
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             last_byte;
    logic [POS_W-1:0] pos;
    logic             gen;
    word_t            counter;
  } job_t;

endpackage

// File: rtl/ccsc_queue.sv
// ----------------------------------------------------------------------------
// ChaCha20 request queue
// Small first-in first-out queue between the front end and the cipher core.
// ----------------------------------------------------------------------------
module ccsc_queue #(
  parameter int unsigned DEPTH = ccsc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ccsc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ccsc_pkg::job_t head
);
  import ccsc_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            slots [DEPTH];
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW-1:0] wr_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/ccsc_front.sv
// ----------------------------------------------------------------------------
// ChaCha20 front end
// Accepts input bytes, tracks the byte position and block count, and marks
// each request that opens a new keystream block.
// ----------------------------------------------------------------------------
module ccsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  ccsc_pkg::data_req_t data_req,
  input  ccsc_pkg::word_t     start_counter,
  input  logic                full,
  output logic                push,
  output ccsc_pkg::job_t      push_job
);
  import ccsc_pkg::*;

  logic [POS_W-1:0] pos;
  word_t            blocks_done;

  assign data_stall = full;
  assign push       = data_valid && !full;

  always_comb begin
    push_job.data_byte = data_req.data_byte;
    push_job.last_byte = data_req.last_byte;
    push_job.pos       = pos;
    push_job.gen       = (pos == '0);
    push_job.counter   = start_counter + blocks_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      blocks_done <= '0;
    end else if (push) begin
      if (data_req.last_byte) begin
        pos         <= '0;
        blocks_done <= '0;
      end else begin
        pos <= pos + 1'b1;
        if (pos == '1) begin
          blocks_done <= blocks_done + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/ccsc_core.sv
// ----------------------------------------------------------------------------
// ChaCha20 cipher core
// Generates keystream blocks with four quarter-round lanes, one add-xor-rotate
// step per lane each cycle, and XORs each byte with its keystream byte.
// ----------------------------------------------------------------------------
module ccsc_core #(
  parameter int unsigned DOUBLE_ROUNDS = ccsc_pkg::DOUBLE_ROUNDS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ccsc_pkg::cipher_cfg_t cfg,
  input  logic                  head_valid,
  input  ccsc_pkg::job_t        head,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output ccsc_pkg::result_req_t result_req
);
  import ccsc_pkg::*;

  localparam int unsigned RoundW = $clog2(DOUBLE_ROUNDS);

  typedef enum logic [3:0] {
    ST_WAIT  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_FEED  = 4'b0100,
    ST_EMIT  = 4'b1000
  } core_state_t;

  core_state_t       state;
  block_t            w;
  block_t            round_next;
  block_t            init_head;
  block_t            init_cur;
  job_t              cur;
  logic [2:0]        step;
  logic [RoundW-1:0] round;
  logic              out_free;
  logic              emit;
  logic              last_step;
  logic [7:0]        ks_head;
  logic [7:0]        ks_cur;

  function automatic block_t init_block(cipher_cfg_t c, word_t ctr);
    block_t b;
    b[0]  = SIGMA_0;
    b[1]  = SIGMA_1;
    b[2]  = SIGMA_2;
    b[3]  = SIGMA_3;
    b[4]  = c.key_a[31:0];
    b[5]  = c.key_a[63:32];
    b[6]  = c.key_b[31:0];
    b[7]  = c.key_b[63:32];
    b[8]  = c.key_c[31:0];
    b[9]  = c.key_c[63:32];
    b[10] = c.key_d[31:0];
    b[11] = c.key_d[63:32];
    b[12] = ctr;
    b[13] = c.nonce_low[31:0];
    b[14] = c.nonce_low[63:32];
    b[15] = c.nonce_high;
    return b;
  endfunction

  function automatic word_t rotl_step(word_t v, logic [1:0] phase);
    word_t r;
    unique case (phase)
      2'd0: r = {v[15:0], v[31:16]};
      2'd1: r = {v[19:0], v[31:20]};
      2'd2: r = {v[23:0], v[31:24]};
      2'd3: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ks_byte(block_t blk, logic [POS_W-1:0] p);
    word_t wd;
    wd = blk[p[5:2]];
    return wd[{p[1:0], 3'b000} +: 8];
  endfunction

  assign init_head = init_block(cfg, head.counter);
  assign init_cur  = init_block(cfg, cur.counter);
  assign out_free  = !result_valid || !result_stall;
  assign emit      = out_free && ((state == ST_WAIT && head_valid && !head.gen) ||
                                  (state == ST_EMIT));
  assign last_step = (step == 3'b111) && (round == RoundW'(DOUBLE_ROUNDS - 1));
  assign ks_head   = ks_byte(w, head.pos);
  assign ks_cur    = ks_byte(w, cur.pos);

  // The upper step bit selects diagonal rounds, the lower two the quarter-round phase.
  always_comb begin
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t x;
    word_t y;
    word_t z;
    word_t sum;
    word_t rz;
    round_next = w;
    for (int l = 0; l < 4; l++) begin
      a = w[l];
      b = step[2] ? w[4 + ((l + 1) % 4)]  : w[4 + l];
      c = step[2] ? w[8 + ((l + 2) % 4)]  : w[8 + l];
      d = step[2] ? w[12 + ((l + 3) % 4)] : w[12 + l];
      x = step[0] ? c : a;
      y = step[0] ? d : b;
      z = step[0] ? b : d;
      sum = x + y;
      rz  = rotl_step(z ^ sum, step[1:0]);
      if (!step[0]) begin
        round_next[l] = sum;
        if (step[2]) begin
          round_next[12 + ((l + 3) % 4)] = rz;
        end else begin
          round_next[12 + l] = rz;
        end
      end else begin
        if (step[2]) begin
          round_next[8 + ((l + 2) % 4)] = sum;
          round_next[4 + ((l + 1) % 4)] = rz;
        end else begin
          round_next[8 + l] = sum;
          round_next[4 + l] = rz;
        end
      end
    end
  end

  always_comb begin
    pop = 1'b0;
    if (state == ST_WAIT && head_valid) begin
      pop = head.gen || out_free;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_WAIT: begin
        if (head_valid && head.gen) begin
          w   <= init_head;
          cur <= head;
        end
        if (head_valid && !head.gen && out_free) begin
          result_req.result_byte <= head.data_byte ^ ks_head;
          result_req.result_last <= head.last_byte;
        end
      end
      ST_ROUND: begin
        w <= round_next;
      end
      ST_FEED: begin
        for (int i = 0; i < 16; i++) begin
          w[i] <= w[i] + init_cur[i];
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          result_req.result_byte <= cur.data_byte ^ ks_cur;
          result_req.result_last <= cur.last_byte;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_WAIT;
      step         <= '0;
      round        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_WAIT: begin
          if (head_valid && head.gen) begin
            step  <= '0;
            round <= '0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          step <= step + 1'b1;
          if (step == 3'b111) begin
            round <= round + 1'b1;
          end
          if (last_step) begin
            state <= ST_FEED;
          end
        end
        ST_FEED: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_WAIT;
          end
        end
        default: begin
          state <= ST_WAIT;
        end
      endcase
    end
  end

endmodule

// File: rtl/chacha20_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher unit
// XORs a byte stream with the ChaCha20 keystream; key, nonce and starting
// block counter are held in configuration registers.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Contents
//  data      data_valid, data_stall, data_req     input byte and last flag
//  result    result_valid, result_stall, result_req  output byte and last flag
//  config    cfg_we, cfg_index, cfg_wdata         key, nonce, start counter
//
//  A request that opens a keystream block passes in the cipher core through
//  the round, feed and emit states, the four-lane quarter-round unit doing
//  one add-xor-rotate step per cycle; every other request is emitted from wait.
//  Synchronous reset returns position, block count and config registers to zero.
//  The front end accepts requests while the core is busy until the queue
//  fills; a stalled result holds in its output register.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_unit #(
  parameter int unsigned DOUBLE_ROUNDS = ccsc_pkg::DOUBLE_ROUNDS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH   = ccsc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 data_valid,
  output logic                                 data_stall,
  input  ccsc_pkg::data_req_t                  data_req,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output ccsc_pkg::result_req_t                result_req,
  input  logic                                 cfg_we,
  input  logic [ccsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ccsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ccsc_pkg::*;

  cipher_cfg_t cfg;
  word_t       start_counter;
  logic        push;
  job_t        push_job;
  logic        full;
  logic        pop;
  logic        head_valid;
  job_t        head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg           <= '0;
      start_counter <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_A:      cfg.key_a      <= cfg_wdata;
        REG_KEY_B:      cfg.key_b      <= cfg_wdata;
        REG_KEY_C:      cfg.key_c      <= cfg_wdata;
        REG_KEY_D:      cfg.key_d      <= cfg_wdata;
        REG_NONCE_LOW:  cfg.nonce_low  <= cfg_wdata;
        REG_NONCE_HIGH: cfg.nonce_high <= cfg_wdata[31:0];
        REG_START_CTR:  start_counter  <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  ccsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_req      (data_req),
    .start_counter (start_counter),
    .full          (full),
    .push          (push),
    .push_job      (push_job)
  );

  ccsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ccsc_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_req   (result_req)
  );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher unit testbench
// Streams byte requests through the cipher under several key, nonce and
// counter settings. Every result is checked against a keystream predictor
// kept inside the testbench, with random gaps, stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb;
  import ccsc_pkg::*;

  localparam int unsigned ROUNDS = 10;
  localparam int unsigned BLOCK_LATENCY = 8 * ROUNDS + 3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic data_valid = 1'b0;
  logic data_stall;
  data_req_t data_req = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_req_t result_req;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: configuration, current keystream block and stream position.
  logic [63:0] key_words[4];
  logic [63:0] nonce_lo;
  word_t nonce_hi;
  word_t first_counter;
  word_t keystream[16];
  word_t mix_w[16];
  logic [POS_W-1:0] stream_pos;
  word_t block_count;

  result_req_t pending_results[$];
  int error_count = 0;
  bit gap_enable = 1'b1;
  bit stall_enable = 1'b1;
  bit hold_request = 1'b0;

  chacha20_stream_cipher_unit #(
    .DOUBLE_ROUNDS(ROUNDS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data_req(data_req),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_req(result_req),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function void mix_quarter(int a, int b, int c, int d);
    mix_w[a] = mix_w[a] + mix_w[b];
    mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d];
    mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b];
    mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d];
    mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
  endfunction

  function void refill_keystream(word_t counter);
    word_t init_w[16];
    init_w[0] = SIGMA_0;
    init_w[1] = SIGMA_1;
    init_w[2] = SIGMA_2;
    init_w[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_words[i][31:0];
      init_w[5 + 2 * i] = key_words[i][63:32];
    end
    init_w[12] = counter;
    init_w[13] = nonce_lo[31:0];
    init_w[14] = nonce_lo[63:32];
    init_w[15] = nonce_hi;
    for (int i = 0; i < 16; i++) begin
      mix_w[i] = init_w[i];
    end
    for (int r = 0; r < ROUNDS; r++) begin
      mix_quarter(0, 4, 8, 12);
      mix_quarter(1, 5, 9, 13);
      mix_quarter(2, 6, 10, 14);
      mix_quarter(3, 7, 11, 15);
      mix_quarter(0, 5, 10, 15);
      mix_quarter(1, 6, 11, 12);
      mix_quarter(2, 7, 8, 13);
      mix_quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      keystream[i] = mix_w[i] + init_w[i];
    end
  endfunction

  // Checks results, follows register writes and predicts each accepted request.
  always @(posedge clk) begin : result_monitor
    result_req_t want;
    word_t ks_word;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        key_words[i] = '0;
      end
      nonce_lo = '0;
      nonce_hi = '0;
      first_counter = '0;
      stream_pos = '0;
      block_count = '0;
      pending_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: %h", result_req);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_req.result_byte !== want.result_byte) begin
            $error("result_byte: expected %h, actual %h", want.result_byte,
                   result_req.result_byte);
            error_count++;
          end
          if (result_req.result_last !== want.result_last) begin
            $error("result_last: expected %b, actual %b", want.result_last,
                   result_req.result_last);
            error_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_A: key_words[0] = cfg_wdata;
          REG_KEY_B: key_words[1] = cfg_wdata;
          REG_KEY_C: key_words[2] = cfg_wdata;
          REG_KEY_D: key_words[3] = cfg_wdata;
          REG_NONCE_LOW: nonce_lo = cfg_wdata;
          REG_NONCE_HIGH: nonce_hi = cfg_wdata[31:0];
          REG_START_CTR: first_counter = cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (data_valid && !data_stall) begin
        if (stream_pos == '0) begin
          refill_keystream(first_counter + block_count);
        end
        ks_word = keystream[stream_pos[5:2]];
        want.result_byte = data_req.data_byte ^ ks_word[stream_pos[1:0] * 8 +: 8];
        want.result_last = data_req.last_byte;
        pending_results.push_back(want);
        stream_pos = stream_pos + 1'b1;
        if (stream_pos == '0) begin
          block_count = block_count + 1;
        end
        if (data_req.last_byte) begin
          stream_pos = '0;
          block_count = '0;
        end
      end
    end
  end

  // Result side: random stall bursts, and one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        result_stall <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    if (gap_enable && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    @(negedge clk);
    data_valid <= 1'b1;
    data_req <= {value, is_last};
    do @(posedge clk); while (data_stall);
  endtask

  task automatic send_message(input int len, input bit closed);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), closed && (i == len - 1));
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    data_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pick_word64();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_config(input logic [63:0] fill, input logic [31:0] counter);
    write_reg(REG_KEY_A, fill);
    write_reg(REG_KEY_B, fill);
    write_reg(REG_KEY_C, fill);
    write_reg(REG_KEY_D, fill);
    write_reg(REG_NONCE_LOW, fill);
    write_reg(REG_NONCE_HIGH, fill);
    write_reg(REG_START_CTR, {32'($urandom), counter});
  endtask

  task automatic test_reset_values();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    wait_idle();
  endtask

  task automatic test_extreme_config();
    load_config('1, '1);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_message(3, 1'b1);
    wait_idle();
  endtask

  task automatic test_midblock_write();
    send_message(6, 1'b0);
    wait_idle();
    write_reg(REG_KEY_A, {$urandom, $urandom});
    write_reg(REG_START_CTR, 64'd5);
    send_message(5, 1'b1);
    wait_idle();
  endtask

  task automatic test_counter_wrap();
    load_config({$urandom, $urandom}, 32'hFFFF_FFFF);
    send_message(150, 1'b1);
    send_message(64, 1'b1);
    send_message(70, 1'b1);
    wait_idle();
  endtask

  task automatic test_result_hold_off();
    hold_request = 1'b1;
    send_message(40, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_phases();
    int sent;
    int len;
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_KEY_A, pick_word64());
      write_reg(REG_KEY_B, pick_word64());
      write_reg(REG_KEY_C, pick_word64());
      write_reg(REG_KEY_D, pick_word64());
      write_reg(REG_NONCE_LOW, pick_word64());
      write_reg(REG_NONCE_HIGH, pick_word64());
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_START_CTR, 64'(32'hFFFF_FFFF - $urandom_range(0, 2)));
      end else begin
        write_reg(REG_START_CTR, pick_word64());
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, pick_word64());
      end
      sent = 0;
      while (sent < 90) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: len = $urandom_range(1, 80);
          7, 8: len = $urandom_range(100, 200);
          default: len = $urandom_range(1, 30);
        endcase
        // Now and then a message stays open so the next settings arrive mid-block.
        send_message(len, !(sent + len >= 90 && $urandom_range(0, 2) == 0));
        sent += len;
      end
      wait_idle();
    end
  endtask

  task automatic test_full_rate();
    gap_enable = 1'b0;
    stall_enable = 1'b0;
    load_config({$urandom, $urandom}, $urandom);
    send_message(130, 1'b1);
    send_message(1, 1'b1);
    send_message(20, 1'b1);
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_extreme_config();
    test_midblock_write();
    test_counter_wrap();
    test_result_hold_off();
    test_random_phases();
    test_full_rate();
    repeat (BLOCK_LATENCY + 20) @(posedge clk);
    if (error_count == 0) begin
      $display("chacha20_stream_cipher_unit: match");
    end else begin
      $display("chacha20_stream_cipher_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("chacha20_stream_cipher_unit: mismatch");
    $finish;
  end

endmodule
